// File: rtl/aism_pkg.sv
package aism_pkg;

    localparam int NUM_CLASSES_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int OUTQ_DEPTH      = 4;

    localparam int POS_W  = 33;
    localparam int ADDR_W = 32;
    localparam int MASK_W = 64;
    localparam int CLS_W  = 6;

    localparam logic [POS_W-1:0] TOP_ADDR = {1'b1, {ADDR_W{1'b0}}};

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic              is_final;
        logic [MASK_W-1:0] mask;
        logic [ADDR_W-1:0] high;
        logic [ADDR_W-1:0] low;
    } seg_t;

    typedef struct packed {
        logic [1:0] num;
        seg_t       first;
        seg_t       second;
    } push_t;

endpackage

// File: rtl/aism_ram.sv
module aism_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/aism_outq.sv
module aism_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  aism_pkg::push_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output aism_pkg::seg_t  m_seg
);

    import aism_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    seg_t             entry_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign pop        = (count_reg != '0) && m_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign room       = count_reg <= CNT_W'(OUTQ_DEPTH - 2);
    assign m_valid    = count_reg != '0;
    assign m_seg      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push.num)
            PUSH_ONE: wr_ptr_next = wr_ptr_reg + PTR_W'(1);
            PUSH_TWO: wr_ptr_next = wr_ptr_reg + PTR_W'(2);
            default:  wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num == PUSH_ONE || push.num == PUSH_TWO) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == PUSH_TWO) begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/address_interval_sweep_merge.sv
// Sweep-line interval merger: boundary requests arrive in ascending address order and
// the block emits merged segments, each with the mask of classes covering it. It takes
// one request per cycle while the output queue has room. The per-class coverage
// counters live in a RAM that is read in the cycle a request is taken and written back
// when the request leaves the sweep stage, where the gap before the event is also
// merged into the pending segment; a write-forward register serves a directly following
// request of the same class. A segment is pushed into a four-entry output queue when the
// request that closes it leaves the sweep stage; the sweep stage waits while fewer than
// two queue slots are free. An end-of-stream request may emit two segments and clears
// all state together, with no clearing pass, so the next stream can start at once.
module address_interval_sweep_merge #(
    parameter int NUM_CLASSES = aism_pkg::NUM_CLASSES_DEF,
    parameter int COUNT_BITS  = aism_pkg::COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // position[32:0], class_id[38:33]
    input  logic [1:0]   s_tuser,   // mode[0], opening[1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // seg_low[31:0], seg_high[63:32], active_mask[127:64]
    output logic         m_tuser    // final_segment[0]
);

    import aism_pkg::*;

    localparam int IDX_W = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;

    logic accept;
    logic fire;
    logic room;

    logic             s1_valid_reg;
    logic             s1_mode_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic [CLS_W-1:0] s1_cls_reg;
    logic             s1_open_reg;

    logic [MASK_W-1:0]      live_reg, live_next;
    logic [POS_W-1:0]       last_reg, last_next;
    logic [ADDR_W-1:0]      pend_low_reg, pend_low_next;
    logic [ADDR_W-1:0]      pend_high_reg, pend_high_next;
    logic [MASK_W-1:0]      pend_mask_reg, pend_mask_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [NUM_CLASSES-1:0] cnt_valid_reg, cnt_valid_next;
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]       fwd_addr_reg;
    logic [COUNT_BITS-1:0]  fwd_data_reg;

    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cnt_old, cnt_new;
    logic [IDX_W-1:0]      idx;
    logic                  in_range;
    logic                  cnt_we;
    logic [POS_W-1:0]      pos_eff, pos_m1;
    logic                  gap, extend, flush_prev;
    push_t                 push;
    seg_t                  out_seg;
    seg_t                  out_seg_q;

    assign accept = s_tvalid && s_tready;
    assign fire   = s1_valid_reg && room;
    assign s_tready = !s1_valid_reg || fire;

    assign idx      = s1_cls_reg[IDX_W-1:0];
    assign in_range = {1'b0, s1_cls_reg} < (CLS_W + 1)'(NUM_CLASSES);
    assign cnt_we   = fire && !s1_mode_reg && in_range;

    aism_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(NUM_CLASSES)
    ) u_cnt_ram (
        .aclk (aclk),
        .we   (cnt_we),
        .waddr(idx),
        .wdata(cnt_new),
        .re   (accept),
        .raddr(s_tdata[POS_W +: IDX_W]),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (!cnt_valid_reg[idx]) begin
            cnt_old = '0;
        end else if (fwd_valid_reg && fwd_addr_reg == idx) begin
            cnt_old = fwd_data_reg;
        end else begin
            cnt_old = ram_rdata;
        end
        if (s1_open_reg) begin
            cnt_new = (cnt_old == {COUNT_BITS{1'b1}}) ? cnt_old : cnt_old + COUNT_BITS'(1);
        end else begin
            cnt_new = (cnt_old == '0) ? cnt_old : cnt_old - COUNT_BITS'(1);
        end
    end

    always_comb begin
        if (s1_mode_reg || s1_pos_reg > TOP_ADDR) begin
            pos_eff = TOP_ADDR;
        end else begin
            pos_eff = s1_pos_reg;
        end
        if (pos_eff < last_reg) begin
            pos_eff = last_reg;
        end
        pos_m1 = pos_eff - POS_W'(1);

        gap        = (pos_eff > last_reg) && (live_reg != '0);
        extend     = pend_valid_reg && (pend_mask_reg == live_reg)
                     && ({1'b0, pend_high_reg} + POS_W'(1) == last_reg);
        flush_prev = gap && !extend && pend_valid_reg;

        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        pend_mask_next  = pend_mask_reg;
        pend_valid_next = pend_valid_reg;
        if (gap) begin
            pend_high_next  = pos_m1[ADDR_W-1:0];
            pend_valid_next = 1'b1;
            if (!extend) begin
                pend_low_next  = last_reg[ADDR_W-1:0];
                pend_mask_next = live_reg;
            end
        end

        out_seg.is_final = 1'b1;
        out_seg.mask     = pend_mask_next;
        out_seg.high     = pend_high_next;
        out_seg.low      = pend_low_next;

        push.num         = PUSH_NONE;
        push.first       = out_seg;
        push.second      = out_seg;
        if (fire) begin
            if (flush_prev) begin
                push.first.is_final = 1'b0;
                push.first.mask     = pend_mask_reg;
                push.first.high     = pend_high_reg;
                push.first.low      = pend_low_reg;
                push.num = (s1_mode_reg && pend_valid_next) ? PUSH_TWO : PUSH_ONE;
            end else if (s1_mode_reg && pend_valid_next) begin
                push.num = PUSH_ONE;
            end
        end

        live_next      = live_reg;
        last_next      = pos_eff;
        cnt_valid_next = cnt_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        if (s1_mode_reg) begin
            live_next       = '0;
            last_next       = '0;
            pend_low_next   = '0;
            pend_high_next  = '0;
            pend_mask_next  = '0;
            pend_valid_next = 1'b0;
            cnt_valid_next  = '0;
            fwd_valid_next  = 1'b0;
        end else if (in_range) begin
            live_next[s1_cls_reg] = cnt_new != '0;
            cnt_valid_next[idx]   = 1'b1;
            fwd_valid_next        = 1'b1;
        end
    end

    aism_outq u_outq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .room   (room),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .m_seg  (out_seg_q)
    );

    assign m_tdata = {out_seg_q.mask, out_seg_q.high, out_seg_q.low};
    assign m_tuser = out_seg_q.is_final;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg <= s_tuser[0];
            s1_open_reg <= s_tuser[1];
            s1_pos_reg  <= s_tdata[POS_W-1:0];
            s1_cls_reg  <= s_tdata[POS_W +: CLS_W];
        end
        if (cnt_we) begin
            fwd_addr_reg <= idx;
            fwd_data_reg <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            live_reg       <= '0;
            last_reg       <= '0;
            pend_low_reg   <= '0;
            pend_high_reg  <= '0;
            pend_mask_reg  <= '0;
            pend_valid_reg <= 1'b0;
            cnt_valid_reg  <= '0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (fire) begin
                live_reg       <= live_next;
                last_reg       <= last_next;
                pend_low_reg   <= pend_low_next;
                pend_high_reg  <= pend_high_next;
                pend_mask_reg  <= pend_mask_next;
                pend_valid_reg <= pend_valid_next;
                cnt_valid_reg  <= cnt_valid_next;
                fwd_valid_reg  <= fwd_valid_next;
            end
        end
    end

    a_end_clears_live : assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s1_mode_reg) |=> (live_reg == '0 && !pend_valid_reg && last_reg == '0))
        else $error("end of stream did not clear the sweep state");

    a_pair_only_at_end : assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == PUSH_TWO) |-> (fire && s1_mode_reg))
        else $error("two segments pushed by a boundary request");

    a_pending_mask_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_mask_reg != '0))
        else $error("pending segment with an empty class mask");

    a_stall_holds_stage : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !room) |=> (s1_valid_reg && $stable(s1_pos_reg)
                                     && $stable(ram_rdata)))
        else $error("stalled sweep stage lost its request or counter data");

endmodule

// File: tb/sv/address_interval_sweep_merge_tb.sv
`timescale 1ns / 1ps

module address_interval_sweep_merge_tb;

    import aism_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 90;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              mode;
        logic [POS_W-1:0]  pos;
        logic [CLS_W-1:0]  cls;
        logic              opening;
    } boundary_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    address_interval_sweep_merge DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    boundary_req_t requests_pending[$];
    seg_t          segments_due[$];

    logic [COUNT_BITS_DEF-1:0] class_depth [NUM_CLASSES_DEF];
    logic [MASK_W-1:0]         covering_mask;
    logic [POS_W-1:0]          sweep_front;
    seg_t                      open_segment;
    bit                        open_segment_valid;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_off_left = 0;
    bit  req_taken = 1'b0;
    int  gen_depth [NUM_CLASSES_DEF];

    function automatic void clear_sweep();
        for (int k = 0; k < NUM_CLASSES_DEF; k++) begin
            class_depth[k] = '0;
        end
        covering_mask = '0;
        sweep_front = '0;
        open_segment = '0;
        open_segment_valid = 1'b0;
    endfunction

    // Accounts for the covered stretch [sweep_front, upto); upto never exceeds 2^32.
    function automatic void merge_gap(logic [POS_W-1:0] upto);
        logic [POS_W-1:0] last_addr;
        last_addr = upto - 1'b1;
        if (upto <= sweep_front || covering_mask == '0) begin
            return;
        end
        if (open_segment_valid && open_segment.mask == covering_mask &&
            {1'b0, open_segment.high} + 1'b1 == sweep_front) begin
            open_segment.high = last_addr[ADDR_W-1:0];
            return;
        end
        if (open_segment_valid) begin
            open_segment.is_final = 1'b0;
            segments_due.push_back(open_segment);
        end
        open_segment.low = sweep_front[ADDR_W-1:0];
        open_segment.high = last_addr[ADDR_W-1:0];
        open_segment.mask = covering_mask;
        open_segment_valid = 1'b1;
    endfunction

    function automatic void sweep_boundary(boundary_req_t r);
        logic [POS_W-1:0]          p;
        logic [COUNT_BITS_DEF-1:0] c;
        if (r.mode) begin
            merge_gap(TOP_ADDR);
            if (open_segment_valid) begin
                open_segment.is_final = 1'b1;
                segments_due.push_back(open_segment);
            end
            clear_sweep();
            return;
        end
        p = r.pos;
        if (p > TOP_ADDR) begin
            p = TOP_ADDR;
        end
        if (p < sweep_front) begin
            p = sweep_front;
        end
        merge_gap(p);
        c = class_depth[r.cls];
        if (r.opening) begin
            if (c != COUNT_MAX) begin
                c = c + 1'b1;
            end
        end else if (c != '0) begin
            c = c - 1'b1;
        end
        class_depth[r.cls] = c;
        covering_mask[r.cls] = (c != '0);
        sweep_front = p;
    endfunction

    always @(posedge aclk) begin
        seg_t got;
        seg_t want;
        got = {m_tuser, m_tdata};
        if (s_tvalid && s_tready) begin
            sweep_boundary(requests_pending.pop_front());
            req_taken = 1'b1;
        end
        if (m_tvalid && m_tready) begin
            if (segments_due.size() == 0) begin
                $error("unexpected segment low=%h high=%h mask=%h final=%b",
                       got.low, got.high, got.mask, got.is_final);
                mismatches++;
            end else begin
                want = segments_due.pop_front();
                if (got.low !== want.low) begin
                    $error("seg_low: expected %h, got %h", want.low, got.low);
                    mismatches++;
                end
                if (got.high !== want.high) begin
                    $error("seg_high: expected %h, got %h", want.high, got.high);
                    mismatches++;
                end
                if (got.mask !== want.mask) begin
                    $error("active_mask: expected %h, got %h", want.mask, got.mask);
                    mismatches++;
                end
                if (got.is_final !== want.is_final) begin
                    $error("final_segment: expected %b, got %b",
                           want.is_final, got.is_final);
                    mismatches++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // A request stays offered until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !req_taken)) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, requests_pending[0].cls, requests_pending[0].pos};
                s_tuser <= {requests_pending[0].opening, requests_pending[0].mode};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_req(input logic mode, input logic [POS_W-1:0] pos,
                            input logic [CLS_W-1:0] cls, input logic opening);
        boundary_req_t r;
        r.mode = mode;
        r.pos = pos;
        r.cls = cls;
        r.opening = opening;
        requests_pending.push_back(r);
    endtask

    // Ascending boundary events over a few classes, with some noise, closed by an end request.
    task automatic build_stream(input int n_events, output int added);
        logic [POS_W-1:0] p;
        logic [CLS_W-1:0] pool [4];
        logic [CLS_W-1:0] c;
        logic             op;
        int               roll;
        for (int k = 0; k < NUM_CLASSES_DEF; k++) begin
            gen_depth[k] = 0;
        end
        for (int k = 0; k < 4; k++) begin
            pool[k] = CLS_W'($urandom_range(NUM_CLASSES_DEF - 1));
        end
        if ($urandom_range(3) == 0) begin
            p = {1'b0, $urandom};
        end else begin
            p = POS_W'($urandom_range(64));
        end
        for (int k = 0; k < n_events; k++) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
            end else if (roll < 75) begin
                p = p + POS_W'($urandom_range(1, 8));
            end else if (roll < 90) begin
                p = p + POS_W'($urandom_range(1, 4096));
            end else if (roll >= 95) begin
                p = p + POS_W'({$urandom_range(1), $urandom});
            end
            c = ($urandom_range(99) < 85) ? pool[$urandom_range(3)]
                                          : CLS_W'($urandom_range(NUM_CLASSES_DEF - 1));
            if (gen_depth[c] > 0) begin
                op = 1'($urandom_range(1));
            end else begin
                op = ($urandom_range(9) != 0);
            end
            gen_depth[c] += op ? 1 : (gen_depth[c] > 0 ? -1 : 0);
            if (roll >= 90 && roll < 95) begin
                push_req(1'b0, p - POS_W'($urandom_range(1, 300)), c, op);
            end else begin
                push_req(1'b0, p, c, op);
            end
        end
        push_req(1'b1, POS_W'({$urandom_range(1), $urandom}), CLS_W'($urandom_range(63)),
                 1'($urandom_range(1)));
        added = n_events + 1;
    endtask

    initial begin
        int added;
        int total;
        clear_sweep();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        push_req(1'b1, 33'h1_2345_6789, 6'd63, 1'b1);
        push_req(1'b0, 33'd0, 6'd0, 1'b1);
        push_req(1'b0, 33'd10, 6'd63, 1'b1);
        push_req(1'b0, 33'd20, 6'd0, 1'b0);
        push_req(1'b0, 33'd5, 6'd7, 1'b0);
        push_req(1'b0, 33'd30, 6'd63, 1'b0);
        push_req(1'b0, 33'd100, 6'd1, 1'b1);
        push_req(1'b0, 33'd200, 6'd1, 1'b0);
        push_req(1'b0, 33'd200, 6'd1, 1'b1);
        push_req(1'b0, 33'd250, 6'd1, 1'b0);
        push_req(1'b0, 33'h0_FFFF_FFF0, 6'd3, 1'b1);
        push_req(1'b0, 33'h1_FFFF_FFFF, 6'd3, 1'b0);
        push_req(1'b0, 33'h1_0000_0000, 6'd9, 1'b1);
        push_req(1'b1, 33'd0, 6'd0, 1'b0);
        push_req(1'b0, 33'd50, 6'd9, 1'b1);
        push_req(1'b0, 33'd60, 6'd10, 1'b1);
        push_req(1'b1, 33'h0_FFFF_FFFF, 6'h2A, 1'b1);
        push_req(1'b0, 33'h0_8000_0000, 6'd40, 1'b1);
        push_req(1'b1, 33'h1_5555_5555, 6'h15, 1'b0);
        push_req(1'b0, 33'd7, 6'd5, 1'b1);
        push_req(1'b0, 33'd9, 6'd5, 1'b0);
        push_req(1'b1, 33'd0, 6'd0, 1'b1);

        // Stack several openings on one class, then close one more time than it was opened.
        repeat (6) push_req(1'b0, 33'd0, 6'd12, 1'b1);
        push_req(1'b0, 33'd5, 6'd13, 1'b1);
        repeat (7) push_req(1'b0, 33'd5, 6'd12, 1'b0);
        push_req(1'b0, 33'd9, 6'd14, 1'b1);
        push_req(1'b1, 33'd0, 6'd0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            while (requests_pending.size() != 0 || segments_due.size() != 0) begin
                @(negedge aclk);
            end
            send_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 8 : 0;
            stall_pct = (ph == 2) ? 57 : (ph == 3) ? 8 : 0;
            if (ph == 0) begin
                hold_off_left = HOLD_OFF_CYCLES;
            end
            total = 0;
            while (total < ITEMS_PER_PHASE) begin
                build_stream($urandom_range(3, 24), added);
                total += added;
            end
        end
        while (requests_pending.size() != 0 || segments_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
